>>> rtl/owm_pkg.sv
package owm_pkg;

	localparam int REG_W          = 10;
	localparam int NUM_REGS       = 8;
	localparam int TIMER_BITS_DEF = 10;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_RST_LOW   = 4'd1;
	localparam logic [3:0] PH_RST_REL   = 4'd2;
	localparam logic [3:0] PH_PRES_WAIT = 4'd3;
	localparam logic [3:0] PH_PRES_LOW  = 4'd4;
	localparam logic [3:0] PH_W_LOW     = 4'd5;
	localparam logic [3:0] PH_W_REL     = 4'd6;
	localparam logic [3:0] PH_R_LOW     = 4'd7;
	localparam logic [3:0] PH_R_WAIT    = 4'd8;
	localparam logic [3:0] PH_R_TAIL    = 4'd9;

	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
	localparam logic [2:0] REG_PRES_WAIT     = 3'd2;
	localparam logic [2:0] REG_PRES_LOW      = 3'd3;
	localparam logic [2:0] REG_SHORT_LOW     = 3'd4;
	localparam logic [2:0] REG_LONG_SLOT     = 3'd5;
	localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [2:0] REG_READ_TAIL     = 3'd7;

	typedef struct packed {
		logic [REG_W-1:0] reset_low_us;
		logic [REG_W-1:0] reset_release_us;
		logic [REG_W-1:0] presence_wait_limit;
		logic [REG_W-1:0] presence_low_limit;
		logic [REG_W-1:0] short_low_us;
		logic [REG_W-1:0] long_slot_us;
		logic [REG_W-1:0] read_sample_us;
		logic [REG_W-1:0] read_tail_us;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] tx_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		logic       cmd_rejected;
		logic       presence_fail;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} res_t;

	typedef struct packed {
		logic [3:0] phase;
		logic       busy;
	} stat_t;

endpackage

>>> rtl/onewire_master_slot_timing_top.sv
// One-wire bus master, one microsecond tick per transaction.
// The accepted item is registered in the input register; the result register loads from it when the output is free.
// One tick per cycle while m_tready does not stall the output; the slot state updates on each advancing tick.
// Reset (arst_n low, asynchronous): bus idle, timer and shift state cleared,
// registers at their defaults, both pipeline registers empty.
module onewire_master_slot_timing_top import owm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [1:0] cmd, [9:2] tx_byte, [10] line_level
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [0] drive_low, [1] busy_res, [2] done_res,
	                              // [10:3] rx_byte, [11] presence_fail, [12] cmd_rejected
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	res_t  res;
	stat_t stat;
	logic  m_valid_q;
	res_t  m_res_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd        <= s_tdata[1:0];
			item_s1.tx_byte    <= s_tdata[9:2];
			item_s1.line_level <= s_tdata[10];
		end
	end

	owm_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	owm_slot #(
		.TIMER_BITS (TIMER_BITS)
	) u_slot (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (!m_valid_q || m_tready)
			m_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_res_q.cmd_rejected, m_res_q.presence_fail, m_res_q.rx_byte,
	                   m_res_q.done_res, m_res_q.busy_res, m_res_q.drive_low};

	// a rejected command can only come while an operation is running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.cmd_rejected |-> stat.busy)
		else $error("command rejected while idle");

	// the completing tick never reports busy, and driving low means still busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_res_q.done_res && m_res_q.busy_res) &&
		(!m_res_q.drive_low || m_res_q.busy_res))
		else $error("inconsistent done/busy/drive result");

	// an accepted transaction is held in the input register next cycle
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted transaction lost");

endmodule

>>> rtl/owm_apb.sv
module owm_apb import owm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic             wr_en;
	logic [2:0]       idx;
	logic [REG_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.reset_low_us        <= REG_W'(750);
			cfg.reset_release_us    <= REG_W'(15);
			cfg.presence_wait_limit <= REG_W'(200);
			cfg.presence_low_limit  <= REG_W'(240);
			cfg.short_low_us        <= REG_W'(2);
			cfg.long_slot_us        <= REG_W'(60);
			cfg.read_sample_us      <= REG_W'(12);
			cfg.read_tail_us        <= REG_W'(50);
		end else if (wr_en) begin
			case (idx)
				REG_RESET_LOW:     cfg.reset_low_us        <= pwdata[REG_W-1:0];
				REG_RESET_RELEASE: cfg.reset_release_us    <= pwdata[REG_W-1:0];
				REG_PRES_WAIT:     cfg.presence_wait_limit <= pwdata[REG_W-1:0];
				REG_PRES_LOW:      cfg.presence_low_limit  <= pwdata[REG_W-1:0];
				REG_SHORT_LOW:     cfg.short_low_us        <= pwdata[REG_W-1:0];
				REG_LONG_SLOT:     cfg.long_slot_us        <= pwdata[REG_W-1:0];
				REG_READ_SAMPLE:   cfg.read_sample_us      <= pwdata[REG_W-1:0];
				REG_READ_TAIL:     cfg.read_tail_us        <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RESET_LOW:     rd_val = cfg.reset_low_us;
			REG_RESET_RELEASE: rd_val = cfg.reset_release_us;
			REG_PRES_WAIT:     rd_val = cfg.presence_wait_limit;
			REG_PRES_LOW:      rd_val = cfg.presence_low_limit;
			REG_SHORT_LOW:     rd_val = cfg.short_low_us;
			REG_LONG_SLOT:     rd_val = cfg.long_slot_us;
			REG_READ_SAMPLE:   rd_val = cfg.read_sample_us;
			REG_READ_TAIL:     rd_val = cfg.read_tail_us;
			default:           rd_val = '0;
		endcase
	end

	assign prdata = {{(32-REG_W){1'b0}}, rd_val};

endmodule

>>> rtl/owm_slot.sv
module owm_slot import owm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res,
	output stat_t stat
);

	localparam int TMAX = (1 << TIMER_BITS) - 1;

	function automatic logic [TIMER_BITS-1:0] sat_len(input logic [REG_W-1:0] v);
		if (32'(v) > TMAX)
			return TMAX[TIMER_BITS-1:0];
		else
			return TIMER_BITS'(v);
	endfunction

	function automatic logic [TIMER_BITS-1:0] min_one(input logic [REG_W-1:0] v);
		logic [REG_W-1:0] w;
		w = (v == '0) ? REG_W'(1) : v;
		return sat_len(w);
	endfunction

	logic [3:0]            phase_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic [2:0]            bit_q;
	logic [7:0]            shift_q;
	logic [7:0]            rx_q;
	logic                  fail_q;

	logic [3:0]            ph;
	logic [TIMER_BITS-1:0] tt;
	logic [2:0]            bc;
	logic [7:0]            sb;
	logic [7:0]            lrx;
	logic                  ff;
	logic                  drive, rej, done;

	logic [TIMER_BITS-1:0] lim_rst_low, lim_rst_rel, lim_wait, lim_plow;
	logic [TIMER_BITS-1:0] lim_short, lim_long, lim_samp, lim_tail;

	assign lim_rst_low = min_one(cfg.reset_low_us);
	assign lim_rst_rel = sat_len(cfg.reset_release_us);
	assign lim_wait    = min_one(cfg.presence_wait_limit);
	assign lim_plow    = min_one(cfg.presence_low_limit);
	assign lim_short   = min_one(cfg.short_low_us);
	assign lim_long    = min_one(cfg.long_slot_us);
	assign lim_samp    = min_one(cfg.read_sample_us);
	assign lim_tail    = sat_len(cfg.read_tail_us);

	always_comb begin
		ph    = phase_q;
		tt    = timer_q;
		bc    = bit_q;
		sb    = shift_q;
		lrx   = rx_q;
		ff    = fail_q;
		drive = 1'b0;
		rej   = 1'b0;
		done  = 1'b0;

		if (ph == PH_IDLE) begin
			tt = '0;
			case (item.cmd)
				CMD_RESET: ph = PH_RST_LOW;
				CMD_WRITE: begin
					sb = item.tx_byte;
					bc = '0;
					ph = PH_W_LOW;
				end
				CMD_READ: begin
					sb = '0;
					bc = '0;
					ph = PH_R_LOW;
				end
				default: ;
			endcase
		end else if (item.cmd != CMD_TICK) begin
			rej = 1'b1;
		end

		case (ph)
			PH_RST_LOW: begin
				drive = 1'b1;
				tt = tt + 1'b1;
				if (tt >= lim_rst_low) begin
					tt = '0;
					ph = (cfg.reset_release_us != '0) ? PH_RST_REL : PH_PRES_WAIT;
				end
			end
			PH_RST_REL: begin
				tt = tt + 1'b1;
				if (tt >= lim_rst_rel) begin
					tt = '0;
					ph = PH_PRES_WAIT;
				end
			end
			PH_PRES_WAIT: begin
				if (item.line_level) begin
					tt = tt + 1'b1;
					if (tt >= lim_wait) begin
						ff   = 1'b1;
						ph   = PH_IDLE;
						tt   = '0;
						done = 1'b1;
					end
				end else begin
					// first low tick already counts toward the presence limit
					ph = PH_PRES_LOW;
					tt = TIMER_BITS'(1);
					if (tt >= lim_plow) begin
						ff   = 1'b1;
						ph   = PH_IDLE;
						tt   = '0;
						done = 1'b1;
					end
				end
			end
			PH_PRES_LOW: begin
				if (!item.line_level) begin
					tt = tt + 1'b1;
					if (tt >= lim_plow) begin
						ff   = 1'b1;
						ph   = PH_IDLE;
						tt   = '0;
						done = 1'b1;
					end
				end else begin
					ff   = 1'b0;
					ph   = PH_IDLE;
					tt   = '0;
					done = 1'b1;
				end
			end
			PH_W_LOW: begin
				drive = 1'b1;
				tt = tt + 1'b1;
				if (tt >= (sb[0] ? lim_short : lim_long)) begin
					tt = '0;
					ph = PH_W_REL;
				end
			end
			PH_W_REL: begin
				tt = tt + 1'b1;
				if (tt >= (sb[0] ? lim_long : lim_short)) begin
					tt = '0;
					sb = {1'b0, sb[7:1]};
					if (bc == 3'd7) begin
						bc   = '0;
						ph   = PH_IDLE;
						done = 1'b1;
					end else begin
						bc = bc + 1'b1;
						ph = PH_W_LOW;
					end
				end
			end
			PH_R_LOW: begin
				drive = 1'b1;
				tt = tt + 1'b1;
				if (tt >= lim_short) begin
					tt = '0;
					ph = PH_R_WAIT;
				end
			end
			PH_R_WAIT: begin
				tt = tt + 1'b1;
				if (tt >= lim_samp) begin
					sb = {item.line_level, sb[7:1]};
					tt = '0;
					if (cfg.read_tail_us != '0) begin
						ph = PH_R_TAIL;
					end else if (bc == 3'd7) begin
						lrx  = sb;
						bc   = '0;
						ph   = PH_IDLE;
						done = 1'b1;
					end else begin
						bc = bc + 1'b1;
						ph = PH_R_LOW;
					end
				end
			end
			PH_R_TAIL: begin
				tt = tt + 1'b1;
				if (tt >= lim_tail) begin
					tt = '0;
					if (bc == 3'd7) begin
						lrx  = sb;
						bc   = '0;
						ph   = PH_IDLE;
						done = 1'b1;
					end else begin
						bc = bc + 1'b1;
						ph = PH_R_LOW;
					end
				end
			end
			PH_IDLE: ;
			default: begin
				ph = PH_IDLE;
				tt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			rx_q    <= '0;
			fail_q  <= 1'b0;
		end else if (step) begin
			phase_q <= ph;
			timer_q <= tt;
			bit_q   <= bc;
			shift_q <= sb;
			rx_q    <= lrx;
			fail_q  <= ff;
		end
	end

	assign res.drive_low     = drive;
	assign res.busy_res      = (ph != PH_IDLE);
	assign res.done_res      = done;
	assign res.rx_byte       = lrx;
	assign res.presence_fail = ff;
	assign res.cmd_rejected  = rej;

	assign stat.phase = phase_q;
	assign stat.busy  = (phase_q != PH_IDLE);

endmodule
